>>> design/assert_macros.svh
// Concurrent assertion helpers used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> design/ctg_pkg.sv
package ctg_pkg;

    localparam int PHASE_BITS = 32;
    localparam int QUOT_BITS = 40;
    localparam int CORDIC_STEPS = 20;
    localparam int INC_DIV_STEPS = 28;
    localparam int PHASE_DIV_STEPS = 56;
    localparam logic [27:0] TURN_K40 = 28'd174992711;
    localparam logic [29:0] CORDIC_GAIN_Q30 = 30'd652032875;

    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_MAX_SPEED = 2'd1;
    localparam logic [1:0] REG_RAMP_TIME = 2'd2;
    localparam logic [1:0] REG_RUN_TIME = 2'd3;

    typedef struct packed {
        logic       load;
        logic       div_step;
        logic       speed_upd;
        logic       mul1;
        logic       mul2;
        logic       phase_upd;
        logic       cordic_init;
        logic       cordic_step;
        logic       result;
        logic [4:0] iter;
    } cmd_t;

    typedef struct packed {
        logic out_valid;
    } status_t;

    function automatic logic [30:0] atan_turns(input logic [4:0] idx);
        logic [30:0] val;
        unique case (idx)
            5'd0:    val = 31'd536870912;
            5'd1:    val = 31'd316933406;
            5'd2:    val = 31'd167458907;
            5'd3:    val = 31'd85004756;
            5'd4:    val = 31'd42667331;
            5'd5:    val = 31'd21354465;
            5'd6:    val = 31'd10679838;
            5'd7:    val = 31'd5340245;
            5'd8:    val = 31'd2670163;
            5'd9:    val = 31'd1335087;
            5'd10:   val = 31'd667544;
            5'd11:   val = 31'd333772;
            5'd12:   val = 31'd166886;
            5'd13:   val = 31'd83443;
            5'd14:   val = 31'd41722;
            5'd15:   val = 31'd20861;
            5'd16:   val = 31'd10430;
            5'd17:   val = 31'd5215;
            5'd18:   val = 31'd2608;
            5'd19:   val = 31'd1304;
            default: val = 31'd0;
        endcase
        return val;
    endfunction

endpackage

>>> design/ctg_ctrl.sv
module ctg_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             out_ready,
    input  ctg_pkg::status_t status,
    output ctg_pkg::cmd_t    cmd
);
    import ctg_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DIV1   = 4'd1;
    localparam logic [3:0] ST_SPEED  = 4'd2;
    localparam logic [3:0] ST_MUL1   = 4'd3;
    localparam logic [3:0] ST_MUL2   = 4'd4;
    localparam logic [3:0] ST_DIV2   = 4'd5;
    localparam logic [3:0] ST_PHASE  = 4'd6;
    localparam logic [3:0] ST_CINIT  = 4'd7;
    localparam logic [3:0] ST_CSTEP  = 4'd8;
    localparam logic [3:0] ST_FINAL  = 4'd9;

    logic [3:0] state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= 6'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.iter   = cnt_reg[4:0];
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = 6'(INC_DIV_STEPS - 1);
                    state_next = ST_DIV1;
                end
            end
            ST_DIV1:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == 6'd0)
                    state_next = ST_SPEED;
                else
                    cnt_next = cnt_reg - 6'd1;
            end
            ST_SPEED:
            begin
                cmd.speed_upd = 1'b1;
                state_next    = ST_MUL1;
            end
            ST_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul2   = 1'b1;
                cnt_next   = 6'(PHASE_DIV_STEPS - 1);
                state_next = ST_DIV2;
            end
            ST_DIV2:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == 6'd0)
                    state_next = ST_PHASE;
                else
                    cnt_next = cnt_reg - 6'd1;
            end
            ST_PHASE:
            begin
                cmd.phase_upd = 1'b1;
                state_next    = ST_CINIT;
            end
            ST_CINIT:
            begin
                cmd.cordic_init = 1'b1;
                cnt_next        = 6'd0;
                state_next      = ST_CSTEP;
            end
            ST_CSTEP:
            begin
                cmd.cordic_step = 1'b1;
                if (cnt_reg == 6'(CORDIC_STEPS - 1))
                    state_next = ST_FINAL;
                else
                    cnt_next = cnt_reg + 6'd1;
            end
            ST_FINAL:
            begin
                if (!status.out_valid || out_ready)
                begin
                    cmd.result = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> design/ctg_dpath.sv
module ctg_dpath (
    input  logic               clk,
    input  logic               rst_n,
    input  ctg_pkg::cmd_t      cmd,
    output ctg_pkg::status_t   status,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [21:0]        cfg_data,
    input  logic [6:0]         period_ms,
    input  logic signed [21:0] present_y_um,
    input  logic signed [21:0] present_z_um,
    input  logic               out_ready,
    output logic               out_valid,
    output logic signed [22:0] target_y_um,
    output logic signed [22:0] target_z_um,
    output logic               finished
);
    import ctg_pkg::*;

    logic [18:0] radius_reg;
    logic [20:0] max_speed_reg;
    logic [15:0] ramp_reg;
    logic [21:0] run_reg;

    logic [31:0]           elapsed_reg, elapsed_next;
    logic [20:0]           speed_reg, speed_next;
    logic [PHASE_BITS-1:0] phase_reg;
    logic [21:0]           base_y_reg, base_z_reg;
    logic [6:0]            period_reg;

    logic [55:0]          num_reg;
    logic [18:0]          rem_reg, div_reg;
    logic [QUOT_BITS-1:0] quot_reg;
    logic [27:0]          prod1_reg;

    logic signed [51:0] x_reg, y_reg;
    logic signed [31:0] z_reg;
    logic [1:0]         quad_reg;

    logic               out_valid_reg;
    logic signed [22:0] ty_reg, tz_reg;
    logic               fin_reg;

    logic [18:0] radius_eff;
    logic [15:0] ramp_eff;
    logic [32:0] el_sum;
    logic [19:0] trial;
    logic        ge;
    logic signed [30:0] s0, s1, s2, inc_s;
    logic signed [51:0] xs, ys;
    logic signed [31:0] atan_s;
    logic signed [51:0] x_rnd, y_rnd;
    logic signed [21:0] cc, ss, cv, sv;
    logic [31:0] phase32;
    logic [55:0] prod2;

    assign radius_eff = (radius_reg == 19'd0) ? 19'd1 : radius_reg;
    assign ramp_eff   = (ramp_reg == 16'd0) ? 16'd1 : ramp_reg;
    assign el_sum     = {1'b0, elapsed_reg} + 33'(period_ms);
    assign elapsed_next = el_sum[32] ? 32'hFFFF_FFFF : el_sum[31:0];

    assign trial = {rem_reg, num_reg[55]};
    assign ge    = trial >= {1'b0, div_reg};

    assign inc_s = 31'(quot_reg[27:0]);
    assign s0    = 31'(speed_reg);

    always_comb
    begin
        s1 = s0;
        if ((speed_reg < max_speed_reg) && (elapsed_reg < 32'(run_reg)))
            s1 = s0 + inc_s;
        s2 = s1;
        if ((s1 > 31'sd0) && (elapsed_reg > 32'(run_reg)))
            s2 = s1 - inc_s;
        if (s2 < 31'sd0)
            speed_next = 21'd0;
        else if (s2 > 31'(max_speed_reg))
            speed_next = max_speed_reg;
        else
            speed_next = s2[20:0];
    end

    assign prod2   = 56'(prod1_reg) * 56'(TURN_K40);
    assign phase32 = 32'(phase_reg) << (32 - PHASE_BITS);

    assign xs     = x_reg >>> cmd.iter;
    assign ys     = y_reg >>> cmd.iter;
    assign atan_s = 32'(atan_turns(cmd.iter));

    assign x_rnd = x_reg + (52'sd1 <<< 29);
    assign y_rnd = y_reg + (52'sd1 <<< 29);
    assign cc    = x_rnd[51:30];
    assign ss    = y_rnd[51:30];

    always_comb
    begin
        unique case (quad_reg)
            2'd0:
            begin
                cv = cc;
                sv = ss;
            end
            2'd1:
            begin
                cv = -ss;
                sv = cc;
            end
            2'd2:
            begin
                cv = -cc;
                sv = -ss;
            end
            default:
            begin
                cv = ss;
                sv = -cc;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg    <= 19'd50000;
            max_speed_reg <= 21'd150000;
            ramp_reg      <= 16'd2000;
            run_reg       <= 22'd60000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RADIUS:    radius_reg    <= cfg_data[18:0];
                REG_MAX_SPEED: max_speed_reg <= cfg_data[20:0];
                REG_RAMP_TIME: ramp_reg      <= cfg_data[15:0];
                REG_RUN_TIME:  run_reg       <= cfg_data[21:0];
                default:       radius_reg    <= radius_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg   <= 32'd0;
            speed_reg     <= 21'd0;
            phase_reg     <= '0;
            base_y_reg    <= 22'd0;
            base_z_reg    <= 22'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                elapsed_reg <= elapsed_next;
                if (elapsed_next == 32'd0)
                begin
                    base_y_reg <= present_y_um;
                    base_z_reg <= present_z_um;
                end
            end
            if (cmd.speed_upd)
                speed_reg <= speed_next;
            if (cmd.phase_upd)
                phase_reg <= phase_reg + quot_reg[QUOT_BITS-1:QUOT_BITS-PHASE_BITS];
            if (cmd.result)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            period_reg <= period_ms;
            num_reg    <= {28'(max_speed_reg) * 28'(period_ms), 28'd0};
            rem_reg    <= 19'd0;
            div_reg    <= 19'(ramp_eff);
        end
        else if (cmd.mul2)
        begin
            num_reg <= prod2;
            rem_reg <= 19'd0;
            div_reg <= radius_eff;
        end
        else if (cmd.div_step)
        begin
            num_reg  <= {num_reg[54:0], 1'b0};
            rem_reg  <= ge ? 19'(trial - {1'b0, div_reg}) : trial[18:0];
            quot_reg <= {quot_reg[QUOT_BITS-2:0], ge};
        end
        if (cmd.mul1)
            prod1_reg <= 28'(period_reg) * 28'(speed_reg);
        if (cmd.cordic_init)
        begin
            x_reg    <= 52'(52'(radius_eff) * 52'(CORDIC_GAIN_Q30));
            y_reg    <= 52'sd0;
            z_reg    <= 32'({2'b00, phase32[29:0]});
            quad_reg <= phase32[31:30];
        end
        else if (cmd.cordic_step)
        begin
            if (!z_reg[31])
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - atan_s;
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + atan_s;
            end
        end
        if (cmd.result)
        begin
            ty_reg  <= 23'(24'(signed'(base_y_reg)) + 24'(radius_eff) - 24'(cv));
            tz_reg  <= 23'(24'(signed'(base_z_reg)) + 24'(sv));
            fin_reg <= {1'b0, elapsed_reg} >= (33'(run_reg) + 33'(ramp_eff));
        end
    end

    assign status.out_valid = out_valid_reg;
    assign out_valid   = out_valid_reg;
    assign target_y_um = ty_reg;
    assign target_z_um = tz_reg;
    assign finished    = fin_reg;

endmodule

>>> design/circular_trajectory_generator.sv
// A request is taken only in IDLE, then runs two bit-serial divisions (28 and 56
// steps) and 20 CORDIC iterations on one shared datapath; FINAL loads the result
// into the output register, waiting while it still holds a result not yet taken.
// The output register holds a finished result while the next request is accepted.
// Reset (rst_n, asynchronous, active low) clears the control, trajectory and valid
// state and loads the default configuration; no clearing pass is needed.
`include "assert_macros.svh"

module circular_trajectory_generator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [21:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [6:0]         period_ms,
    input  logic signed [21:0] present_y_um,
    input  logic signed [21:0] present_z_um,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [22:0] target_y_um,
    output logic signed [22:0] target_z_um,
    output logic               finished
);
    import ctg_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    ctg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    ctg_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg_valid & cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .period_ms    (period_ms),
        .present_y_um (present_y_um),
        .present_z_um (present_z_um),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .target_y_um  (target_y_um),
        .target_z_um  (target_z_um),
        .finished     (finished)
    );

    `ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
    `ASSERT_SAME(a_result_has_room, cmd.result, !out_valid || out_ready)
    `ASSERT_SAME(a_cordic_iter_range, cmd.cordic_step, cmd.iter < 5'(CORDIC_STEPS))
    `ASSERT_NEXT(a_result_sets_valid, cmd.result, out_valid)

endmodule

>>> bench/tb_top.sv
module tb_top;
    import ctg_pkg::*;

    typedef enum logic { ROW_TICK, ROW_WRITE } row_kind_t;

    typedef struct {
        row_kind_t         kind;
        logic [1:0]        idx;
        logic [21:0]       data;
        logic [6:0]        period;
        logic signed [21:0] y;
        logic signed [21:0] z;
        logic              has_fin;
        logic              fin;
    } step_row_t;

    typedef struct {
        logic signed [22:0] y;
        logic signed [22:0] z;
        logic               fin;
    } target_t;

    localparam longint ATAN_TURNS [20] = '{
        536870912, 316933406, 167458907, 85004756, 42667331,
        21354465, 10679838, 5340245, 2670163, 1335087,
        667544, 333772, 166886, 83443, 41722,
        20861, 10430, 5215, 2608, 1304
    };

    localparam int DRAIN_CYCLES = 120;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [21:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [6:0]         period_ms;
    logic signed [21:0] present_y_um;
    logic signed [21:0] present_z_um;
    logic               out_valid;
    logic               out_ready;
    logic signed [22:0] target_y_um;
    logic signed [22:0] target_z_um;
    logic               finished;

    circular_trajectory_generator dut (.*);

    // Shadow copy of the configuration and the trajectory state.
    longint radius_um, max_speed, ramp_ms, run_ms;
    longint elapsed, speed, base_y, base_z;
    logic [31:0] phase;

    target_t target_q [$];
    int send_idle, recv_idle;
    int errors, ticks, targets_seen, reg_writes;

    step_row_t directed [] = '{
        '{ROW_TICK, 0, 0, 0, 22'sh1FFFFF, -22'sh200000, 1, 0},
        '{ROW_TICK, 0, 0, 0, -22'sh200000, 22'sh1FFFFF, 1, 0},
        '{ROW_TICK, 0, 0, 100, 0, 0, 0, 0},
        '{ROW_TICK, 0, 0, 127, 1000, -1000, 0, 0},
        '{ROW_WRITE, REG_RUN_TIME, 0, 0, 0, 0, 0, 0},
        '{ROW_WRITE, REG_RAMP_TIME, 0, 0, 0, 0, 0, 0},
        '{ROW_TICK, 0, 0, 1, 5, 7, 1, 1},
        '{ROW_WRITE, REG_RADIUS, 0, 0, 0, 0, 0, 0},
        '{ROW_TICK, 0, 0, 50, -3, 3, 1, 1},
        '{ROW_WRITE, REG_MAX_SPEED, 22'h3FFFFF, 0, 0, 0, 0, 0},
        '{ROW_WRITE, REG_RADIUS, 1, 0, 0, 0, 0, 0},
        '{ROW_WRITE, REG_RUN_TIME, 22'h3FFFFF, 0, 0, 0, 0, 0},
        '{ROW_TICK, 0, 0, 100, 0, 0, 1, 0},
        '{ROW_TICK, 0, 0, 100, 0, 0, 1, 0},
        '{ROW_WRITE, REG_MAX_SPEED, 1000, 0, 0, 0, 0, 0},
        '{ROW_TICK, 0, 0, 100, 0, 0, 0, 0},
        '{ROW_WRITE, REG_RAMP_TIME, 22'h00FFFF, 0, 0, 0, 0, 0},
        '{ROW_WRITE, REG_RADIUS, 22'h07FFFF, 0, 0, 0, 0, 0},
        '{ROW_TICK, 0, 0, 0, 22'sh155555, -22'sh155555, 0, 0},
        '{ROW_TICK, 0, 0, 100, 22'sh2AAAAA, 22'sh2AAAAA, 0, 0}
    };

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic target_t advance_circle(logic [6:0] p, logic signed [21:0] py,
                                               logic signed [21:0] pz);
        longint pl, rad, rmp, inc, dlt, x, y, zr, xs, ys, cc, ss, cv, sv, ty, tz;
        target_t t;
        pl = p;
        rad = (radius_um == 0) ? 1 : radius_um;
        rmp = (ramp_ms == 0) ? 1 : ramp_ms;
        elapsed = elapsed + pl;
        if (elapsed > 64'sd4294967295)
            elapsed = 64'sd4294967295;
        if (elapsed == 0)
        begin
            base_y = py;
            base_z = pz;
        end
        inc = (max_speed * pl) / rmp;
        if (speed < max_speed && elapsed < run_ms)
            speed = speed + inc;
        if (speed > 0 && elapsed > run_ms)
            speed = speed - inc;
        if (speed < 0)
            speed = 0;
        if (speed > max_speed)
            speed = max_speed;
        dlt = ((pl * speed * 64'sd174992711) / rad) >>> 8;
        phase = phase + dlt[31:0];
        zr = phase[29:0];
        x = rad * 64'sd652032875;
        y = 0;
        for (int i = 0; i < 20; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (zr >= 0)
            begin
                x = x - ys;
                y = y + xs;
                zr = zr - ATAN_TURNS[i];
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                zr = zr + ATAN_TURNS[i];
            end
        end
        cc = (x + (64'sd1 << 29)) >>> 30;
        ss = (y + (64'sd1 << 29)) >>> 30;
        case (phase[31:30])
            2'd0:    begin cv = cc;  sv = ss;  end
            2'd1:    begin cv = -ss; sv = cc;  end
            2'd2:    begin cv = -cc; sv = -ss; end
            default: begin cv = ss;  sv = -cc; end
        endcase
        ty = base_y + rad - cv;
        tz = base_z + sv;
        t.y = ty[22:0];
        t.z = tz[22:0];
        t.fin = (elapsed >= run_ms + rmp);
        return t;
    endfunction

    task automatic send_tick(logic [6:0] p, logic signed [21:0] py, logic signed [21:0] pz,
                             logic has_fin, logic fin);
        target_t t;
        if ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle);
        end
        in_valid <= 1'b1;
        period_ms <= p;
        present_y_um <= py;
        present_z_um <= pz;
        do
            @(posedge clk);
        while (!in_ready);
        t = advance_circle(p, py, pz);
        if (has_fin)
            t.fin = fin;
        target_q.push_back(t);
        ticks++;
    endtask

    task automatic write_reg(logic [1:0] idx, logic [21:0] data);
        in_valid <= 1'b0;
        while (target_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_RADIUS:    radius_um = data[18:0];
            REG_MAX_SPEED: max_speed = data[20:0];
            REG_RAMP_TIME: ramp_ms = data[15:0];
            default:       run_ms = data[21:0];
        endcase
        reg_writes++;
    endtask

    task automatic run_phase(int n, int s_idle, int r_idle, logic [21:0] rad,
                             logic [21:0] vmax, logic [21:0] ramp, logic [21:0] run);
        logic [6:0] p;
        write_reg(REG_RADIUS, rad);
        write_reg(REG_MAX_SPEED, vmax);
        write_reg(REG_RAMP_TIME, ramp);
        write_reg(REG_RUN_TIME, run);
        send_idle = s_idle;
        recv_idle = r_idle;
        for (int i = 0; i < n; i++)
        begin
            p = ($urandom_range(9) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(100));
            send_tick(p, 22'($urandom), 22'($urandom), 1'b0, 1'b0);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                targets_seen++;
                if (target_q.size() == 0)
                begin
                    $display("%0t: unexpected target y=%0d z=%0d finished=%0b", $time,
                             target_y_um, target_z_um, finished);
                    errors++;
                end
                else if (target_y_um !== target_q[0].y || target_z_um !== target_q[0].z
                         || finished !== target_q[0].fin)
                begin
                    $display("%0t: expected y=%0d z=%0d finished=%0b, got y=%0d z=%0d finished=%0b",
                             $time, target_q[0].y, target_q[0].z, target_q[0].fin,
                             target_y_um, target_z_um, finished);
                    errors++;
                    void'(target_q.pop_front());
                end
                else
                    void'(target_q.pop_front());
            end
            out_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    initial
    begin
        #30000000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        period_ms = '0;
        present_y_um = '0;
        present_z_um = '0;
        out_ready = 1'b0;
        radius_um = 50000;
        max_speed = 150000;
        ramp_ms = 2000;
        run_ms = 60000;
        elapsed = 0;
        speed = 0;
        phase = '0;
        base_y = 0;
        base_z = 0;
        errors = 0;
        ticks = 0;
        targets_seen = 0;
        reg_writes = 0;
        send_idle = 0;
        recv_idle = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            if (directed[i].kind == ROW_WRITE)
                write_reg(directed[i].idx, directed[i].data);
            else
                send_tick(directed[i].period, directed[i].y, directed[i].z,
                          directed[i].has_fin, directed[i].fin);
        end

        run_phase(310, 13, 78, 500000, 2000000, 60000, 22'(elapsed + 3000));
        run_phase(310, 78, 13, 1, 22'($urandom_range(2000000)), 1,
                  22'(elapsed + $urandom_range(10000)));
        run_phase(310, 0, 0, 22'($urandom_range(500000, 1)), 22'($urandom_range(2000000)),
                  22'($urandom_range(3000, 1)), 22'(elapsed + $urandom_range(15000, 5000)));

        in_valid <= 1'b0;
        while (target_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d ticks and %0d register writes, checked %0d targets.",
                 ticks, reg_writes, targets_seen);
        $display("Covered speed ramps, cruise, slowdown, phase wrap and %0d mismatches.",
                 errors);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

>>> files.f
+incdir+design
design/ctg_pkg.sv
design/ctg_ctrl.sv
design/ctg_dpath.sv
design/circular_trajectory_generator.sv
bench/tb_top.sv
